@@ rtl/rlc_ladder_heun_step_core_macros.svh @@
// ----------------------------------------------------------------------------
// rlc_ladder_heun_step_core_macros
// Assertion macros shared by the ladder integrator.
// ----------------------------------------------------------------------------
// The macros sample on clk and are disabled while rst_n is low.
`ifndef RLC_LADDER_HEUN_STEP_CORE_MACROS_SVH
`define RLC_LADDER_HEUN_STEP_CORE_MACROS_SVH

// Same-cycle implication.
`define RLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RLC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rlc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlc_pkg
// Types, register codes and fixed-point helpers for the ladder integrator.
// ----------------------------------------------------------------------------
package rlc_pkg;

    localparam int MAX_NODES = 5;
    localparam int COEF_W    = 12;
    localparam int FIELDS_W  = 60;
    localparam int OPA_W     = 38;
    localparam int OPB_W     = 13;
    localparam int PROD_W    = 51;
    localparam int WIDE_W    = 53;

    localparam logic [2:0] REG_SC      = 3'd0;
    localparam logic [2:0] REG_SI      = 3'd1;
    localparam logic [2:0] REG_G       = 3'd2;
    localparam logic [2:0] REG_R       = 3'd3;
    localparam logic [2:0] REG_ATRIAL  = 3'd4;
    localparam logic [2:0] REG_INIT    = 3'd5;

    localparam logic signed [31:0] ATRIAL_RESET = 32'sd131072;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic signed [31:0] inflow_start;
        logic signed [31:0] inflow_end;
        logic               restart;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pressure_0;
        logic signed [31:0] pressure_1;
        logic signed [31:0] pressure_2;
        logic signed [31:0] pressure_3;
        logic signed [31:0] pressure_4;
        logic signed [31:0] flow_0;
        logic signed [31:0] flow_1;
        logic signed [31:0] flow_2;
        logic signed [31:0] flow_3;
        logic signed [31:0] flow_4;
    } out_item_t;

    typedef struct packed {
        logic [FIELDS_W-1:0] sc;
        logic [FIELDS_W-1:0] si;
        logic [FIELDS_W-1:0] g;
        logic [FIELDS_W-1:0] r;
        logic signed [31:0]  atrial;
        logic [FIELDS_W-1:0] init;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_OHM,
        OP_RQ,
        OP_VSI,
        OP_NODE
    } mul_op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_PREDICT,
        ACT_COMMIT,
        ACT_RESTART,
        ACT_OUTPUT
    } dp_act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RESTART,
        ST_LOAD,
        ST_SEG,
        ST_NODE,
        ST_DRAIN,
        ST_UPDATE,
        ST_EFF,
        ST_EFF_DRAIN,
        ST_OUT
    } ctl_state_t;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        mul_op_t    op;
        logic [2:0] idx;
        logic       stage;
        dp_act_t    act;
    } dp_cmd_t;

    typedef struct packed {
        logic restart;
    } dp_status_t;

    function automatic logic [COEF_W-1:0] coef12(input logic [FIELDS_W-1:0] fields,
                                                 input logic [2:0] i);
        return fields[COEF_W*i +: COEF_W];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > 53'sd2147483647)
            return 32'sh7fffffff;
        else if (x < -53'sd2147483648)
            return 32'sh80000000;
        else
            return x[31:0];
    endfunction

    // Round half up: floor(x / 2^s + 1/2).
    function automatic logic signed [WIDE_W-1:0] rnd_shift(
        input logic signed [WIDE_W-1:0] x, input int unsigned s);
        logic signed [WIDE_W-1:0] biased;
        biased = x + (53'sd1 <<< (s - 1));
        return biased >>> s;
    endfunction

endpackage

@@ rtl/rlc_cfg.sv @@
// ----------------------------------------------------------------------------
// rlc_cfg
// Configuration register bank behind the APB-style port.
// ----------------------------------------------------------------------------
module rlc_cfg
    import rlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] index;

    assign index = paddr[5:3];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (index)
                REG_SC:     cfg_next.sc     = pwdata[FIELDS_W-1:0];
                REG_SI:     cfg_next.si     = pwdata[FIELDS_W-1:0];
                REG_G:      cfg_next.g      = pwdata[FIELDS_W-1:0];
                REG_R:      cfg_next.r      = pwdata[FIELDS_W-1:0];
                REG_ATRIAL: cfg_next.atrial = pwdata[31:0];
                REG_INIT:   cfg_next.init   = pwdata[FIELDS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sc: '0, si: '0, g: '0, r: '0, atrial: ATRIAL_RESET, init: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (index)
            REG_SC:     prdata = {4'b0, cfg_reg.sc};
            REG_SI:     prdata = {4'b0, cfg_reg.si};
            REG_G:      prdata = {4'b0, cfg_reg.g};
            REG_R:      prdata = {4'b0, cfg_reg.r};
            REG_ATRIAL: prdata = {32'b0, cfg_reg.atrial};
            REG_INIT:   prdata = {4'b0, cfg_reg.init};
            default:    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/rlc_ctl.sv @@
// ----------------------------------------------------------------------------
// rlc_ctl
// Sequencer: walks the segment, node and update steps of each Heun step.
// ----------------------------------------------------------------------------
module rlc_ctl
    import rlc_pkg::*;
#(
    parameter int NODE_COUNT = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output logic       result_valid,
    input  logic       result_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    ctl_state_t    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    phase_reg, phase_next;
    logic          stage_reg, stage_next;
    logic          out_valid_reg, out_valid_next;
    logic          last;
    logic          out_free;

    assign last     = (idx_reg == IW'(NODE_COUNT - 1));
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        stage_next = stage_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_START;
            end
            ST_START:
            begin
                idx_next   = '0;
                phase_next = '0;
                stage_next = 1'b0;
                state_next = status.restart ? ST_RESTART : ST_LOAD;
            end
            ST_RESTART:
                state_next = ST_EFF;
            ST_LOAD:
                state_next = ST_SEG;
            ST_SEG:
            begin
                if (phase_reg == 2'd2)
                begin
                    phase_next = '0;
                    if (last)
                    begin
                        idx_next   = '0;
                        state_next = ST_NODE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_NODE:
            begin
                if (last)
                    state_next = ST_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_DRAIN:
                state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                idx_next   = '0;
                phase_next = '0;
                if (stage_reg)
                begin
                    state_next = ST_EFF;
                end
                else
                begin
                    stage_next = 1'b1;
                    state_next = ST_SEG;
                end
            end
            ST_EFF:
            begin
                if (last)
                    state_next = ST_EFF_DRAIN;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_EFF_DRAIN:
                state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.op      = OP_OHM;
        cmd.act     = ACT_NONE;
        cmd.idx     = 3'(idx_reg);
        cmd.stage   = stage_reg;
        cmd.capture = (state_reg == ST_IDLE) && item_valid;
        case (state_reg)
            ST_RESTART:
                cmd.act = ACT_RESTART;
            ST_LOAD:
                cmd.act = ACT_LOAD;
            ST_SEG:
            begin
                cmd.mul_en = 1'b1;
                case (phase_reg)
                    2'd0:    cmd.op = OP_OHM;
                    2'd1:    cmd.op = OP_RQ;
                    default: cmd.op = OP_VSI;
                endcase
            end
            ST_NODE:
            begin
                cmd.mul_en = 1'b1;
                cmd.op     = OP_NODE;
            end
            ST_UPDATE:
                cmd.act = stage_reg ? ACT_COMMIT : ACT_PREDICT;
            ST_EFF:
                cmd.mul_en = 1'b1;
            ST_OUT:
            begin
                if (out_free)
                    cmd.act = ACT_OUTPUT;
            end
            default:
                cmd.act = ACT_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
        if (cmd.act == ACT_OUTPUT)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            phase_reg     <= '0;
            stage_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            stage_reg     <= stage_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

@@ rtl/rlc_dp.sv @@
// ----------------------------------------------------------------------------
// rlc_dp
// Datapath: ladder state, working copy, shared multiplier and result register.
// ----------------------------------------------------------------------------
module rlc_dp
    import rlc_pkg::*;
#(
    parameter int NODE_COUNT = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  in_item_t   item,
    input  cfg_t       cfg,
    output dp_status_t status,
    output out_item_t  result
);

    localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    word_t p_reg   [NODE_COUNT];
    word_t p_next  [NODE_COUNT];
    word_t q_reg   [NODE_COUNT];
    word_t q_next  [NODE_COUNT];
    word_t pw_reg  [NODE_COUNT];
    word_t pw_next [NODE_COUNT];
    word_t qw_reg  [NODE_COUNT];
    word_t qw_next [NODE_COUNT];
    word_t qe_reg  [NODE_COUNT];
    word_t qe_next [NODE_COUNT];
    word_t dp_reg  [NODE_COUNT];
    word_t dp_next [NODE_COUNT];
    word_t dq_reg  [NODE_COUNT];
    word_t dq_next [NODE_COUNT];
    word_t d1p_reg [NODE_COUNT];
    word_t d1p_next[NODE_COUNT];
    word_t d1q_reg [NODE_COUNT];
    word_t d1q_next[NODE_COUNT];

    logic signed [32:0] drop_w [NODE_COUNT];
    logic signed [32:0] net_w  [NODE_COUNT];
    logic               si_nz  [NODE_COUNT];
    word_t              rep_p  [MAX_NODES];
    word_t              rep_q  [MAX_NODES];

    in_item_t   in_reg, in_next;
    out_item_t  result_reg, result_next;

    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     wb_en_reg, wb_en_next;
    mul_op_t                  wb_op_reg, wb_op_next;
    logic [IW-1:0]            wb_idx_reg, wb_idx_next;

    logic [IW-1:0]            idx;
    logic signed [32:0]       qin;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [WIDE_W-1:0] prod_r8;
    logic signed [WIDE_W-1:0] prod_r20;
    word_t                    ohm_flow;

    assign idx = cmd.idx[IW-1:0];
    assign qin = cmd.stage ? 33'(in_reg.inflow_end) : 33'(in_reg.inflow_start);

    // The last segment drains into the atrium; node 0 is fed by the inflow.
    for (genvar e = 0; e < NODE_COUNT; e++)
    begin : g_seg
        if (e == NODE_COUNT - 1)
        begin : g_last
            assign drop_w[e] = 33'(pw_reg[e]) - 33'(cfg.atrial);
        end
        else
        begin : g_mid
            assign drop_w[e] = 33'(pw_reg[e]) - 33'(pw_reg[e+1]);
        end
        if (e == 0)
        begin : g_first
            assign net_w[e] = qin - 33'(qe_reg[e]);
        end
        else
        begin : g_inner
            assign net_w[e] = 33'(qe_reg[e-1]) - 33'(qe_reg[e]);
        end
        assign si_nz[e] = (coef12(cfg.si, 3'(e)) != '0);
    end

    assign prod_r8  = rnd_shift(WIDE_W'(prod_reg), 8);
    assign prod_r20 = rnd_shift(WIDE_W'(prod_reg), 20);
    assign ohm_flow = sat32(prod_r8);

    always_comb
    begin
        case (cmd.op)
            OP_OHM:
            begin
                mul_a = OPA_W'(drop_w[idx]);
                mul_b = OPB_W'({1'b0, coef12(cfg.g, cmd.idx)});
            end
            OP_RQ:
            begin
                mul_a = OPA_W'(qw_reg[idx]);
                mul_b = OPB_W'({1'b0, coef12(cfg.r, cmd.idx)});
            end
            OP_VSI:
            begin
                // The resistive drop R*Q comes straight from the previous product.
                mul_a = OPA_W'(drop_w[idx]) - OPA_W'(prod_r8);
                mul_b = OPB_W'({1'b0, coef12(cfg.si, cmd.idx)});
            end
            OP_NODE:
            begin
                mul_a = OPA_W'(net_w[idx]);
                mul_b = OPB_W'({1'b0, coef12(cfg.sc, cmd.idx)});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign wb_en_next  = cmd.mul_en;
    assign wb_op_next  = cmd.op;
    assign wb_idx_next = idx;
    assign in_next     = cmd.capture ? item : in_reg;

    always_comb
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            p_next[i]   = p_reg[i];
            q_next[i]   = q_reg[i];
            pw_next[i]  = pw_reg[i];
            qw_next[i]  = qw_reg[i];
            qe_next[i]  = qe_reg[i];
            dp_next[i]  = dp_reg[i];
            dq_next[i]  = dq_reg[i];
            d1p_next[i] = d1p_reg[i];
            d1q_next[i] = d1q_reg[i];
        end

        case (cmd.act)
            ACT_LOAD:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    pw_next[i] = p_reg[i];
                    qw_next[i] = q_reg[i];
                end
            end
            ACT_PREDICT:
            begin
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    d1p_next[i] = dp_reg[i];
                    d1q_next[i] = dq_reg[i];
                    pw_next[i]  = sat32(WIDE_W'(p_reg[i]) + WIDE_W'(dp_reg[i]));
                    qw_next[i]  = sat32(WIDE_W'(q_reg[i]) + WIDE_W'(dq_reg[i]));
                end
            end
            ACT_COMMIT:
            begin
                // New value is the state plus the rounded mean of both increments.
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    p_next[i] = sat32(WIDE_W'(p_reg[i]) +
                        ((WIDE_W'(d1p_reg[i]) + WIDE_W'(dp_reg[i]) + 53'sd1) >>> 1));
                    q_next[i] = sat32(WIDE_W'(q_reg[i]) +
                        ((WIDE_W'(d1q_reg[i]) + WIDE_W'(dq_reg[i]) + 53'sd1) >>> 1));
                    pw_next[i] = p_next[i];
                    qw_next[i] = q_next[i];
                end
            end
            ACT_RESTART:
            begin
                // Initial pressures are in eighths of a unit, hence the 13-bit shift.
                for (int i = 0; i < NODE_COUNT; i++)
                begin
                    p_next[i]  = word_t'({7'b0, coef12(cfg.init, 3'(i)), 13'b0});
                    q_next[i]  = '0;
                    pw_next[i] = p_next[i];
                    qw_next[i] = '0;
                end
            end
            default:
            begin
            end
        endcase

        if (wb_en_reg)
        begin
            case (wb_op_reg)
                OP_OHM:
                    qe_next[wb_idx_reg] = si_nz[wb_idx_reg] ? qw_reg[wb_idx_reg] : ohm_flow;
                OP_VSI:
                    dq_next[wb_idx_reg] = si_nz[wb_idx_reg] ? word_t'(prod_r20[31:0]) : '0;
                OP_NODE:
                    dp_next[wb_idx_reg] = word_t'(prod_r20[31:0]);
                default:
                begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_rep
        if (g < NODE_COUNT)
        begin : g_used
            assign rep_p[g] = p_reg[g];
            assign rep_q[g] = qe_reg[g];
        end
        else
        begin : g_unused
            assign rep_p[g] = '0;
            assign rep_q[g] = '0;
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (cmd.act == ACT_OUTPUT)
        begin
            result_next.pressure_0 = rep_p[0];
            result_next.pressure_1 = rep_p[1];
            result_next.pressure_2 = rep_p[2];
            result_next.pressure_3 = rep_p[3];
            result_next.pressure_4 = rep_p[4];
            result_next.flow_0     = rep_q[0];
            result_next.flow_1     = rep_q[1];
            result_next.flow_2     = rep_q[2];
            result_next.flow_3     = rep_q[3];
            result_next.flow_4     = rep_q[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_en_reg <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                p_reg[i] <= '0;
                q_reg[i] <= '0;
            end
        end
        else
        begin
            wb_en_reg <= wb_en_next;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                p_reg[i] <= p_next[i];
                q_reg[i] <= q_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        result_reg <= result_next;
        prod_reg   <= prod_next;
        wb_op_reg  <= wb_op_next;
        wb_idx_reg <= wb_idx_next;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            pw_reg[i]  <= pw_next[i];
            qw_reg[i]  <= qw_next[i];
            qe_reg[i]  <= qe_next[i];
            dp_reg[i]  <= dp_next[i];
            dq_reg[i]  <= dq_next[i];
            d1p_reg[i] <= d1p_next[i];
            d1q_reg[i] <= d1q_next[i];
        end
    end

    assign status.restart = in_reg.restart;
    assign result         = result_reg;

endmodule

@@ rtl/rlc_ladder_heun_step_core.sv @@
// ----------------------------------------------------------------------------
// rlc_ladder_heun_step_core
// Heun (RK2) integrator for a compliance / resistance-inductance ladder.
// ----------------------------------------------------------------------------
// The item channel (item_valid, item_stall, item) takes one transaction per
// step: the inflow at the start and end of the step and a restart flag. The
// result channel (result_valid, result_stall, result) returns one transaction
// per item with the node pressures and effective segment flows.
// A step runs on one shared multiplier: two derivative passes of 3*NODE_COUNT
// segment products and NODE_COUNT node products each, then NODE_COUNT products
// for the reported flows; a restart item runs only the NODE_COUNT flow
// products. The next item can be taken in the cycle its predecessor's
// result appears. One item is in work at a time; item_stall is high from
// acceptance until the result has been placed in the output register, which
// may still be waiting for the receiver while the next item is taken.
// When the receiver stalls, the result is held and the block waits at the end
// of its next item until the register is free.
// Reset clears the ladder state to zero and the registers to their defaults
// (atrial pressure 2.0). The configuration port must be written only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "rlc_ladder_heun_step_core_macros.svh"

module rlc_ladder_heun_step_core
    import rlc_pkg::*;
#(
    parameter int NODE_COUNT = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    assign pready = 1'b1;

    rlc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rlc_ctl #(.NODE_COUNT(NODE_COUNT)) u_ctl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    rlc_dp #(.NODE_COUNT(NODE_COUNT)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .cfg    (cfg),
        .status (status),
        .result (result)
    );

    `RLC_ASSERT_NXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy")
    `RLC_ASSERT_IMP(a_ready_on_result, $rose(result_valid), !item_stall, "busy at result")
    `RLC_ASSERT_IMP(a_unused_zero, result_valid && (NODE_COUNT < MAX_NODES), (result.pressure_4 == 32'sd0) && (result.flow_4 == 32'sd0), "unused node")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Heun ladder integrator testbench
// Writes several register settings over the configuration port, drives
// directed and random step and restart transactions with random idling on
// both sides, and checks every result against a bit-exact fixed-point model
// of the five-node ladder kept in the testbench.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rlc_pkg::*;

    localparam int NODES = 5;
    localparam int CYCLE_LIMIT = 600000;

    typedef longint ladder_vec_t [NODES];

    typedef struct {
        in_item_t stim;
        bit       known_zero;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        item_valid;
    logic        item_stall;
    in_item_t    item;
    logic        result_valid;
    logic        result_stall;
    out_item_t   result;

    // Register copies and ladder state of the model.
    logic [63:0] m_sc, m_si, m_g, m_r, m_init;
    longint      m_atrial;
    ladder_vec_t m_press, m_flow;

    out_item_t   pending_results[$];
    bit          item_known_zero;
    int          mismatches;
    int          cycles;
    bit          idling_on;
    bit          long_hold;

    rlc_ladder_heun_step_core #(.NODE_COUNT(NODES)) uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- model
    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint round_shift(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint field12(input logic [63:0] fields, input int i);
        return longint'((fields >> (12 * i)) & 64'hFFF);
    endfunction

    function automatic longint pressure_drop(input ladder_vec_t p, input int e);
        return p[e] - ((e < NODES - 1) ? p[e + 1] : m_atrial);
    endfunction

    function automatic ladder_vec_t effective_flows(input ladder_vec_t p,
                                                    input ladder_vec_t q);
        ladder_vec_t qe;
        for (int e = 0; e < NODES; e++)
            if (field12(m_si, e) != 0)
                qe[e] = q[e];
            else
                qe[e] = clamp32(round_shift(pressure_drop(p, e) * field12(m_g, e), 8));
        return qe;
    endfunction

    task automatic ladder_increments(input ladder_vec_t p, input ladder_vec_t q,
                                     input longint qin, output ladder_vec_t dp,
                                     output ladder_vec_t dq);
        ladder_vec_t qe;
        longint      v;
        longint      net;
        qe = effective_flows(p, q);
        for (int i = 0; i < NODES; i++)
        begin
            dq[i] = 0;
            if (field12(m_si, i) != 0)
            begin
                v = pressure_drop(p, i) - round_shift(field12(m_r, i) * q[i], 8);
                dq[i] = round_shift(v * field12(m_si, i), 20);
            end
            net = ((i == 0) ? qin : qe[i - 1]) - qe[i];
            dp[i] = round_shift(net * field12(m_sc, i), 20);
        end
    endtask

    task automatic advance_ladder(input in_item_t x, output out_item_t y);
        ladder_vec_t d1p, d1q, d2p, d2q, pp, pq, qe;
        if (x.restart)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                m_press[i] = field12(m_init, i) <<< 13;
                m_flow[i]  = 0;
            end
        end
        else
        begin
            ladder_increments(m_press, m_flow, longint'(x.inflow_start), d1p, d1q);
            for (int i = 0; i < NODES; i++)
            begin
                pp[i] = clamp32(m_press[i] + d1p[i]);
                pq[i] = clamp32(m_flow[i] + d1q[i]);
            end
            ladder_increments(pp, pq, longint'(x.inflow_end), d2p, d2q);
            for (int i = 0; i < NODES; i++)
            begin
                m_press[i] = clamp32(m_press[i] + ((d1p[i] + d2p[i] + 1) >>> 1));
                m_flow[i]  = clamp32(m_flow[i] + ((d1q[i] + d2q[i] + 1) >>> 1));
            end
        end
        qe = effective_flows(m_press, m_flow);
        y.pressure_0 = m_press[0][31:0];
        y.pressure_1 = m_press[1][31:0];
        y.pressure_2 = m_press[2][31:0];
        y.pressure_3 = m_press[3][31:0];
        y.pressure_4 = m_press[4][31:0];
        y.flow_0 = qe[0][31:0];
        y.flow_1 = qe[1][31:0];
        y.flow_2 = qe[2][31:0];
        y.flow_3 = qe[3][31:0];
        y.flow_4 = qe[4][31:0];
    endtask

    // ------------------------------------------------------ scoreboarding
    always @(posedge clk)
    begin
        out_item_t y;
        if (rst_n && item_valid && !item_stall)
        begin
            advance_ladder(item, y);
            if (item_known_zero)
                y = '0;
            pending_results = {pending_results, y};
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        logic [31:0] w, g;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int k = 0; k < 10; k++)
                begin
                    w = want[319 - 32 * k -: 32];
                    g = result[319 - 32 * k -: 32];
                    if (w !== g)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%s_%0d: expected %h, got %h",
                                     (k < 5) ? "pressure" : "flow", k % 5, w, g);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("rlc_ladder_heun_step_core: mismatch");
            $finish;
        end
    end

    // -------------------------------------------------------------- receiver
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                n = 0;
                result_stall <= 1'b1;
                while (n < 400)
                begin
                    @(posedge clk);
                    n++;
                end
                long_hold = 1'b0;
                result_stall <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------- register access
    task automatic reg_access(input bit wr, input logic [5:0] addr,
                              input logic [63:0] data, output logic [63:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] rd;
        logic [63:0] masked;
        masked = (idx == REG_ATRIAL) ? (value & 64'hFFFF_FFFF)
                                     : (value & 64'h0FFF_FFFF_FFFF_FFFF);
        reg_access(1'b1, {idx, 3'b000}, value, rd);
        case (idx)
            REG_SC:     m_sc = masked;
            REG_SI:     m_si = masked;
            REG_G:      m_g = masked;
            REG_R:      m_r = masked;
            REG_ATRIAL: m_atrial = longint'(signed'(masked[31:0]));
            REG_INIT:   m_init = masked;
            default:    ;
        endcase
        reg_access(1'b0, {idx, 3'b000}, 64'd0, rd);
        if ((idx == REG_ATRIAL) ? (rd[31:0] !== masked[31:0])
                                : (rd[59:0] !== masked[59:0]))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d read back %h, expected %h", idx, rd, masked);
        end
    endtask

    function automatic logic [63:0] coef_fields(input int mode);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < NODES; i++)
            case (mode)
                1: v[12 * i +: 12] = 12'hFFF;
                2: v[12 * i +: 12] = 12'($urandom);
                3: v[12 * i +: 12] = ($urandom_range(0, 1) == 0) ? 12'd0
                                     : 12'($urandom_range(1, 600));
                default: v[12 * i +: 12] = 12'd0;
            endcase
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // ------------------------------------------------------------ sender
    task automatic send_item(input in_item_t x, input bit known_zero);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        item_valid      <= 1'b1;
        item            <= x;
        item_known_zero <= known_zero;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
    endtask

    task automatic stop_items();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] random_inflow();
        case ($urandom_range(0, 3))
            0:       return 32'($urandom);
            1:       return 32'sd0;
            default: return 32'($urandom_range(0, 32'h00C8_0000)) - 32'sh0010_0000;
        endcase
    endfunction

    task automatic run_table(input stim_row_t rows[$]);
        foreach (rows[k])
            send_item(rows[k].stim, rows[k].known_zero);
        stop_items();
    endtask

    initial
    begin
        stim_row_t   rows[$];
        in_item_t    x;
        logic [63:0] rd;
        int          sent;

        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_valid = 1'b0; item = '0; item_known_zero = 1'b0;
        mismatches = 0; cycles = 0; idling_on = 1'b1; long_hold = 1'b0;
        m_sc = '0; m_si = '0; m_g = '0; m_r = '0; m_init = '0;
        m_atrial = longint'(ATRIAL_RESET);
        for (int i = 0; i < NODES; i++)
        begin
            m_press[i] = 0;
            m_flow[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all coefficients at reset nothing moves, whatever the inflow.
        rows = '{
            '{'{32'sd0, 32'sd0, 1'b0}, 1'b1},
            '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b1},
            '{'{32'sh80000000, 32'sh80000000, 1'b0}, 1'b1},
            '{'{32'sh7fffffff, 32'sh80000000, 1'b1}, 1'b1},
            '{'{32'sh80000000, 32'sh7fffffff, 1'b0}, 1'b1}
        };
        run_table(rows);
        wait_drained();

        // Mixed ladder: segments 0 and 2 inductive, the rest resistive.
        write_reg(REG_SC, {12'd400, 12'd300, 12'd200, 12'd100, 12'd50});
        write_reg(REG_SI, {12'd0, 12'd0, 12'd700, 12'd0, 12'd900});
        write_reg(REG_G, {12'd40, 12'd200, 12'd90, 12'd300, 12'd128});
        write_reg(REG_R, {12'd256, 12'd20, 12'd300, 12'd10, 12'd4095});
        write_reg(REG_ATRIAL, 64'h0000_0000_0003_0000);
        write_reg(REG_INIT, {12'd16, 12'd40, 12'd80, 12'd400, 12'd4095});
        // An address past the last register must leave everything alone.
        reg_access(1'b1, 6'd48, 64'hFFFF_FFFF_FFFF_FFFF, rd);
        rows = '{
            '{'{32'sd0, 32'sd0, 1'b1}, 1'b0},
            '{'{32'sd0, 32'sd0, 1'b0}, 1'b0},
            '{'{32'sh0050_0000, 32'sh0060_0000, 1'b0}, 1'b0},
            '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b0},
            '{'{32'sh7fffffff, 32'sh7fffffff, 1'b0}, 1'b0},
            '{'{32'sh80000000, 32'sh80000000, 1'b0}, 1'b0},
            '{'{32'sh80000000, 32'sh7fffffff, 1'b0}, 1'b0},
            '{'{32'sh0001_0000, 32'shffff_0000, 1'b1}, 1'b0},
            '{'{32'sh0010_0000, 32'sh0010_0000, 1'b0}, 1'b0},
            '{'{32'sh0010_0000, 32'sh0010_0000, 1'b0}, 1'b0}
        };
        run_table(rows);
        wait_drained();

        // Random phases; phase 0 maxes every coefficient, phase 1 zeroes sc.
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(REG_SC, coef_fields(phase == 0 ? 1 : (phase == 1 ? 0 : 3)));
            write_reg(REG_SI, coef_fields(phase == 0 ? 1 : (phase == 5 ? 2 : 3)));
            write_reg(REG_G, coef_fields(phase == 0 ? 1 : (phase == 1 ? 2 : 3)));
            write_reg(REG_R, coef_fields(phase == 0 ? 1 : 3));
            write_reg(REG_ATRIAL, (phase == 0) ? 64'h7FFF_FFFF :
                                  (phase == 1) ? 64'h8000_0000 : 64'($urandom));
            write_reg(REG_INIT, coef_fields(phase == 0 ? 1 : 2));
            idling_on = (phase != 7);
            x = '{32'sd0, 32'sd0, 1'b1};
            send_item(x, 1'b0);
            for (sent = 0; sent < 80; sent++)
            begin
                if (phase == 3 && sent == 10)
                    long_hold = 1'b1;
                x.inflow_start = random_inflow();
                x.inflow_end   = ($urandom_range(0, 3) == 0) ? random_inflow()
                                 : x.inflow_start + 32'($urandom_range(0, 65536)) - 32'sd32768;
                x.restart      = ($urandom_range(0, 24) == 0);
                send_item(x, 1'b0);
            end
            stop_items();
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("rlc_ladder_heun_step_core: match");
        else
            $display("rlc_ladder_heun_step_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rlc_pkg.sv
rtl/rlc_cfg.sv
rtl/rlc_ctl.sv
rtl/rlc_dp.sv
rtl/rlc_ladder_heun_step_core.sv
tb/testbench.sv
